[design/mmwf_pkg.sv]
// Shared types and constants of the masked majority window filter.
package mmwf_pkg;

  typedef struct packed {
    logic vld;
    logic last;
  } beat_t;

  typedef struct packed {
    logic c0;
    logic real_cell;
    logic ok_up;
    logic ok_mid;
    logic emit;
    logic last;
  } ctl_t;

  localparam int RF_ZERO_BIT = 0;
  localparam int RF_ND_BIT   = 1;
  localparam int WIN_CELLS   = 9;
  localparam int CENTER      = 4;
  localparam int CNT_W       = 4;

  localparam logic [1:0] REG_COLUMNS       = 2'd0;
  localparam logic [1:0] REG_ROWS_TOTAL    = 2'd1;
  localparam logic [1:0] REG_NODATA_ENABLE = 2'd2;
  localparam logic [1:0] REG_NODATA_VALUE  = 2'd3;

endpackage

[design/mmwf_line_buf.sv]
// Line buffer memory with registered read and write-to-read forwarding.
module mmwf_line_buf #(
  parameter int DEPTH = 1024,
  parameter int DW    = 34,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_q_r;
  logic [DW-1:0] fwd_q_r;
  logic          fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (en) begin
      rd_q_r  <= mem[rd_addr];
      fwd_q_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_q_r : rd_q_r;

endmodule

[design/mmwf_count.sv]
// Match count stage: occurrences of each window value among valid cells.
module mmwf_count #(
  parameter int VB = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  mmwf_pkg::beat_t               in_beat,
  input  logic [VB-1:0]                 in_v [mmwf_pkg::WIN_CELLS],
  input  logic [mmwf_pkg::WIN_CELLS-1:0] in_ok,
  input  logic [1:0]                    in_rf,
  output mmwf_pkg::beat_t               out_beat,
  output logic [VB-1:0]                 out_v [mmwf_pkg::WIN_CELLS],
  output logic [mmwf_pkg::WIN_CELLS-1:0] out_ok,
  output logic [mmwf_pkg::CNT_W-1:0]    out_n [mmwf_pkg::WIN_CELLS],
  output logic [1:0]                    out_rf
);
  import mmwf_pkg::*;

  logic [CNT_W-1:0] n_nxt [WIN_CELLS];
  beat_t            beat_r;

  always_comb begin
    for (int i = 0; i < WIN_CELLS; i++) begin
      n_nxt[i] = '0;
      for (int j = 0; j < WIN_CELLS; j++) begin
        n_nxt[i] = n_nxt[i] + CNT_W'(in_ok[j] && (in_v[j] == in_v[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_v  <= in_v;
      out_ok <= in_ok;
      out_n  <= n_nxt;
      out_rf <= in_rf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else if (en) begin
      beat_r <= in_beat;
    end
  end

  assign out_beat = beat_r;

endmodule

[design/mmwf_select.sv]
// Majority select tree and output register with center keep rule.
module mmwf_select #(
  parameter int VB = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  mmwf_pkg::beat_t               in_beat,
  input  logic [VB-1:0]                 in_v [mmwf_pkg::WIN_CELLS],
  input  logic [mmwf_pkg::WIN_CELLS-1:0] in_ok,
  input  logic [mmwf_pkg::CNT_W-1:0]    in_n [mmwf_pkg::WIN_CELLS],
  input  logic [1:0]                    in_rf,
  output logic                          out_vld,
  output logic [VB-1:0]                 out_val,
  output logic                          out_last
);
  import mmwf_pkg::*;

  function automatic logic better(input logic a_ok, input logic [CNT_W-1:0] a_n,
                                  input logic [VB-1:0] a_v, input logic b_ok,
                                  input logic [CNT_W-1:0] b_n, input logic [VB-1:0] b_v);
    return a_ok && (!b_ok || (a_n > b_n) ||
                    ((a_n == b_n) && ($signed(a_v) < $signed(b_v))));
  endfunction

  logic [VB-1:0]    gv_nxt [3];
  logic [CNT_W-1:0] gn_nxt [3];
  logic [2:0]       gok_nxt;
  logic [VB-1:0]    gv_r [3];
  logic [CNT_W-1:0] gn_r [3];
  logic [2:0]       gok_r;
  logic [VB-1:0]    ctr_r;
  logic             keep_r;
  beat_t            beat_r;
  logic [VB-1:0]    bv;
  logic [CNT_W-1:0] bn;
  logic             bok;
  logic [VB-1:0]    val_nxt;
  logic             out_vld_r;
  logic [VB-1:0]    out_val_r;
  logic             out_last_r;

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      gv_nxt[g]  = in_v[3*g];
      gn_nxt[g]  = in_n[3*g];
      gok_nxt[g] = in_ok[3*g];
      for (int k = 1; k < 3; k++) begin
        if (better(in_ok[3*g+k], in_n[3*g+k], in_v[3*g+k],
                   gok_nxt[g], gn_nxt[g], gv_nxt[g])) begin
          gv_nxt[g]  = in_v[3*g+k];
          gn_nxt[g]  = in_n[3*g+k];
          gok_nxt[g] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    bv  = gv_r[0];
    bn  = gn_r[0];
    bok = gok_r[0];
    for (int g = 1; g < 3; g++) begin
      if (better(gok_r[g], gn_r[g], gv_r[g], bok, bn, bv)) begin
        bv  = gv_r[g];
        bn  = gn_r[g];
        bok = 1'b1;
      end
    end
    val_nxt = keep_r ? ctr_r : bv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gv_r      <= gv_nxt;
      gn_r      <= gn_nxt;
      gok_r     <= gok_nxt;
      ctr_r     <= in_v[CENTER];
      keep_r    <= !in_ok[CENTER] || (in_rf != 2'b00);
      out_val_r <= val_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r     <= '0;
      out_vld_r  <= 1'b0;
      out_last_r <= 1'b0;
    end else if (en) begin
      beat_r     <= in_beat;
      out_vld_r  <= beat_r.vld;
      out_last_r <= beat_r.last;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_val  = out_val_r;
  assign out_last = out_last_r;

endmodule

[design/masked_majority_window_filter_core.sv]
// Top level: position tracking, line buffer and window, count and select pipeline.
// Path to out_tvalid: stage 1, stage 2, count, select group and output registers.
// Throughput: one beat per cycle; the whole pipeline advances on one enable
//   that holds while a result waits on out_tready.
// Reset: rst_n synchronous; clears position, registers to their defaults and
//   all valid bits. Line buffers are not cleared.
module masked_majority_window_filter_core #(
  parameter int MAX_COLUMNS = 1024,
  parameter int VALUE_BITS  = 16,
  localparam int IDW = ((2 * VALUE_BITS + 7) / 8) * 8,
  localparam int ODW = ((VALUE_BITS + 7) / 8) * 8,
  localparam int CDW = (VALUE_BITS > 16) ? VALUE_BITS : 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [IDW-1:0] in_tdata,   // cell_value, rule_value
  input  logic           in_tuser,   // op
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [ODW-1:0] out_tdata,  // next_value
  output logic           out_tlast,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [CDW-1:0] cfg_data
);
  import mmwf_pkg::*;

  localparam int VB   = VALUE_BITS;
  localparam int AW   = $clog2(MAX_COLUMNS);
  localparam int CNTW = $clog2(MAX_COLUMNS + 1);
  localparam int EW   = (CNTW > 11) ? CNTW : 11;
  localparam int LDW  = 2 * VB + 2;

  logic [10:0]   cols_r;
  logic [15:0]   rows_r;
  logic          nd_en_r;
  logic [VB-1:0] nd_val_r;
  logic [16:0]   row_r;
  logic [AW-1:0] col_r;

  function automatic logic is_nd(input logic [VB-1:0] x);
    return nd_en_r && (x == nd_val_r);
  endfunction

  logic          adv, fire, take, in_rng, op_flush, wrap;
  logic [EW-1:0] cols_eff;
  logic [16:0]   rows17;
  logic [VB-1:0] cv, rv;
  ctl_t          ctl;
  logic [16:0]   row_nxt;
  logic [AW-1:0] col_nxt;

  assign cv       = in_tdata[VB-1:0];
  assign rv       = in_tdata[2*VB-1:VB];
  assign op_flush = in_tuser;
  assign adv      = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign fire     = in_tvalid && in_tready;

  always_comb begin
    if (cols_r == 11'd0) begin
      cols_eff = EW'(1);
    end else if (EW'(cols_r) > EW'(MAX_COLUMNS)) begin
      cols_eff = EW'(MAX_COLUMNS);
    end else begin
      cols_eff = EW'(cols_r);
    end
    rows17        = (rows_r == 16'd0) ? 17'd1 : {1'b0, rows_r};
    in_rng        = row_r < rows17;
    take          = fire && !(in_rng && op_flush);
    ctl.c0        = (col_r == '0);
    ctl.real_cell = in_rng && !op_flush;
    ctl.ok_up     = (row_r >= 17'd2) && (row_r <= rows17 + 17'd1);
    ctl.ok_mid    = (row_r >= 17'd1) && (row_r <= rows17);
    ctl.emit      = ctl.c0 ? ctl.ok_up : ctl.ok_mid;
    ctl.last      = ctl.c0 && ctl.ok_up && (row_r == rows17 + 17'd1);
    wrap          = (EW'(col_r) + EW'(1)) >= cols_eff;
    col_nxt       = wrap ? '0 : col_r + AW'(1);
    row_nxt       = wrap ? row_r + 17'd1 : row_r;
    if (ctl.last) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r   <= 11'd1024;
      rows_r   <= 16'd1024;
      nd_en_r  <= 1'b0;
      nd_val_r <= '0;
      row_r    <= '0;
      col_r    <= '0;
    end else begin
      if (take) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COLUMNS: begin
            cols_r <= cfg_data[10:0];
            row_r  <= '0;
            col_r  <= '0;
          end
          REG_ROWS_TOTAL: begin
            rows_r <= cfg_data[15:0];
            row_r  <= '0;
            col_r  <= '0;
          end
          REG_NODATA_ENABLE: nd_en_r <= cfg_data[0];
          REG_NODATA_VALUE:  nd_val_r <= cfg_data[VB-1:0];
          default: ;
        endcase
      end
    end
  end

  // stage 1: line buffer read data and window column
  logic          s1_vld_r;
  ctl_t          s1_ctl_r;
  logic [AW-1:0] s1_addr_r;
  logic [VB-1:0] s1_cv_r;
  logic [1:0]    s1_rf_r;
  logic          s1_ok2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl_r  <= ctl;
      s1_addr_r <= col_r;
      s1_cv_r   <= ctl.real_cell ? cv : '0;
      s1_rf_r   <= ctl.real_cell ? {is_nd(rv), rv == '0} : 2'b00;
      s1_ok2_r  <= ctl.real_cell && !is_nd(cv);
    end
  end

  logic [LDW-1:0] ln_rd, ln_wr;
  logic           ln_we;
  logic [VB-1:0]  up_v, mid_v;

  assign up_v  = ln_rd[VB-1:0];
  assign mid_v = ln_rd[2*VB-1:VB];
  assign ln_wr = {s1_rf_r, s1_cv_r, mid_v};
  assign ln_we = s1_vld_r && adv;

  mmwf_line_buf #(
    .DEPTH (MAX_COLUMNS),
    .DW    (LDW)
  ) u_line_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .rd_addr (col_r),
    .wr_en   (ln_we),
    .wr_addr (s1_addr_r),
    .wr_data (ln_wr),
    .rd_data (ln_rd)
  );

  logic [VB-1:0] nc_v [3];
  logic [2:0]    nc_ok;
  logic [VB-1:0] w1_v_r [3];
  logic [VB-1:0] w2_v_r [3];
  logic [2:0]    w1_ok_r, w2_ok_r;
  logic [1:0]    w2_rf_r;
  logic [VB-1:0] win_v [WIN_CELLS];
  logic [WIN_CELLS-1:0] win_ok;

  always_comb begin
    nc_v[0]  = up_v;
    nc_ok[0] = s1_ctl_r.ok_up && !is_nd(up_v);
    nc_v[1]  = mid_v;
    nc_ok[1] = s1_ctl_r.ok_mid && !is_nd(mid_v);
    nc_v[2]  = s1_cv_r;
    nc_ok[2] = s1_ok2_r;
    for (int b = 0; b < 3; b++) begin
      win_v[b]      = w1_v_r[b];
      win_ok[b]     = w1_ok_r[b];
      win_v[3+b]    = w2_v_r[b];
      win_ok[3+b]   = w2_ok_r[b];
      win_v[6+b]    = s1_ctl_r.c0 ? '0 : nc_v[b];
      win_ok[6+b]   = !s1_ctl_r.c0 && nc_ok[b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_ok_r <= '0;
      w2_ok_r <= '0;
    end else if (ln_we) begin
      w1_ok_r <= s1_ctl_r.c0 ? 3'b000 : w2_ok_r;
      w2_ok_r <= nc_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (ln_we) begin
      w1_v_r  <= w2_v_r;
      w2_v_r  <= nc_v;
      w2_rf_r <= ln_rd[LDW-1:2*VB];
    end
  end

  // stage 2: window registered for the count stage
  beat_t                s2_beat_r;
  logic [VB-1:0]        s2_v_r [WIN_CELLS];
  logic [WIN_CELLS-1:0] s2_ok_r;
  logic [1:0]           s2_rf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_beat_r <= '0;
    end else if (adv) begin
      s2_beat_r.vld  <= s1_vld_r && s1_ctl_r.emit;
      s2_beat_r.last <= s1_ctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_v_r  <= win_v;
      s2_ok_r <= win_ok;
      s2_rf_r <= w2_rf_r;
    end
  end

  beat_t                s3_beat;
  logic [VB-1:0]        s3_v [WIN_CELLS];
  logic [WIN_CELLS-1:0] s3_ok;
  logic [CNT_W-1:0]     s3_n [WIN_CELLS];
  logic [1:0]           s3_rf;

  mmwf_count #(
    .VB (VB)
  ) u_count (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_beat  (s2_beat_r),
    .in_v     (s2_v_r),
    .in_ok    (s2_ok_r),
    .in_rf    (s2_rf_r),
    .out_beat (s3_beat),
    .out_v    (s3_v),
    .out_ok   (s3_ok),
    .out_n    (s3_n),
    .out_rf   (s3_rf)
  );

  logic [VB-1:0] res_val;

  mmwf_select #(
    .VB (VB)
  ) u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_beat  (s3_beat),
    .in_v     (s3_v),
    .in_ok    (s3_ok),
    .in_n     (s3_n),
    .in_rf    (s3_rf),
    .out_vld  (out_tvalid),
    .out_val  (res_val),
    .out_last (out_tlast)
  );

  assign out_tdata = ODW'(res_val);

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= rows17 + 17'd1)
    else $error("row position beyond drain end");

  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (take && ctl.last) |=> (row_r == '0) && (col_r == '0))
    else $error("frame end did not restart position");

  a_flush_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_rng && op_flush) |=> !s1_vld_r)
    else $error("flush during frame entered pipeline");

endmodule

[verif/testbench.sv]
// Self-checking testbench for the masked majority window filter core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mmwf_pkg::*;

  localparam int MAXC = 1024;
  localparam int CYCLE_LIMIT = 3000000;
  localparam bit OP_CELL = 1'b0;
  localparam bit OP_FLUSH = 1'b1;

  typedef enum logic [1:0] {ROW_CFG, ROW_CELL, ROW_FLUSH} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [15:0] data;
    logic [15:0] rule;
    bit          has_exp;
    logic [15:0] exp_value;
    bit          exp_last;
  } dir_row_t;

  typedef struct packed {
    logic [2:0][15:0] v;
    logic [2:0]       ok;
    logic [1:0]       rf;
  } win_col_t;

  typedef struct packed {
    logic [15:0] value;
    bit          last;
  } filt_result_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [31:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast;
  logic [15:0] out_tdata;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  masked_majority_window_filter_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the filter state
  logic [15:0] upper_buf [MAXC];
  logic [15:0] middle_buf [MAXC];
  logic [1:0]  rule_flag_buf [MAXC];
  win_col_t    win [3];
  int unsigned row_pos, col_pos;
  logic [10:0] columns_reg;
  logic [15:0] rows_reg;
  logic        nd_en;
  logic [15:0] nd_val;

  filt_result_t pending_results[$];
  int mismatches, cycles, items;
  bit tx_fast, rx_fast, hold_req;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("masked_majority_window_filter_core regression: fail");
      $finish;
    end
  end

  function automatic bit is_nodata(logic [15:0] v);
    return nd_en && v == nd_val;
  endfunction

  function automatic logic [15:0] majority_of(win_col_t l, win_col_t m, win_col_t r);
    win_col_t cs [3];
    logic signed [15:0] best, v;
    int bestn, n;
    cs[0] = l; cs[1] = m; cs[2] = r;
    if (!m.ok[1]) return m.v[1];
    best = m.v[1];
    bestn = 0;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) begin
        if (!cs[a].ok[b]) continue;
        v = cs[a].v[b];
        n = 0;
        for (int x = 0; x < 3; x++)
          for (int y = 0; y < 3; y++)
            if (cs[x].ok[y] && cs[x].v[y] == v) n++;
        if (n > bestn || (n == bestn && v < best)) begin
          bestn = n;
          best = v;
        end
      end
    if (m.rf != 2'b00) return m.v[1];
    return best;
  endfunction

  function automatic void clear_window();
    row_pos = 0;
    col_pos = 0;
    for (int i = 0; i < 3; i++) win[i] = '0;
  endfunction

  function automatic int unsigned eff_columns();
    if (columns_reg == 0) return 1;
    if (columns_reg > MAXC) return MAXC;
    return columns_reg;
  endfunction

  function automatic bit filter_step(bit op, logic [15:0] cv, logic [15:0] rv,
                                     output filt_result_t res);
    int unsigned cols, rows, r, c;
    bit real_cell, emit, last;
    win_col_t nc;
    cols = eff_columns();
    rows = (rows_reg == 0) ? 1 : rows_reg;
    r = row_pos;
    c = col_pos;
    real_cell = (op == OP_CELL);
    emit = 0;
    last = 0;
    res = '0;
    if (r >= rows) real_cell = 0;
    else if (!real_cell) return 0;
    if (c >= cols) c = 0;
    nc.v[0] = upper_buf[c];
    nc.ok[0] = r >= 2 && r - 2 < rows && !is_nodata(upper_buf[c]);
    nc.v[1] = middle_buf[c];
    nc.ok[1] = r >= 1 && r - 1 < rows && !is_nodata(middle_buf[c]);
    nc.v[2] = real_cell ? cv : 16'd0;
    nc.ok[2] = real_cell && !is_nodata(cv);
    nc.rf = rule_flag_buf[c];
    if (c == 0) begin
      if (r >= 2 && r - 2 < rows) begin
        emit = 1;
        res.value = majority_of(win[1], win[2], '0);
        last = (r - 2 == rows - 1);
      end
      win[0] = '0;
      win[1] = '0;
      win[2] = nc;
    end else begin
      win[0] = win[1];
      win[1] = win[2];
      win[2] = nc;
      if (r >= 1 && r - 1 < rows) begin
        emit = 1;
        res.value = majority_of(win[0], win[1], win[2]);
      end
    end
    upper_buf[c] = middle_buf[c];
    middle_buf[c] = real_cell ? cv : 16'd0;
    rule_flag_buf[c] = real_cell ? {is_nodata(rv), rv == 16'd0} : 2'b00;
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
    end
    row_pos = r;
    col_pos = c;
    if (last) clear_window();
    res.last = last;
    return emit;
  endfunction

  task automatic wait_drained();
    in_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    wait_drained();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_COLUMNS:       begin columns_reg = data[10:0]; clear_window(); end
      REG_ROWS_TOTAL:    begin rows_reg = data; clear_window(); end
      REG_NODATA_ENABLE: nd_en = data[0];
      REG_NODATA_VALUE:  nd_val = data;
    endcase
    @(posedge clk);
  endtask

  task automatic send_beat(bit op, logic [15:0] cv, logic [15:0] rv,
                           output bit emitted, output filt_result_t res);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {rv, cv};
    do @(posedge clk); while (!in_tready);
    emitted = filter_step(op, cv, rv, res);
    if (emitted) pending_results.push_back(res);
  endtask

  // results
  initial begin
    filt_result_t want;
    int gap;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      gap = hold_req ? 400 : (rx_fast ? 0 : $urandom_range(0, 17));
      hold_req = 0;
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: value %0d last %0b",
                                       $signed(out_tdata), out_tlast);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.value || out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                     $signed(want.value), want.last, $signed(out_tdata), out_tlast);
        end
      end
    end
  end

  function automatic logic [15:0] pick_cell();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, 3)) - 16'd1;
      6, 7: return nd_val;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_rule();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return nd_val;
      default: return 16'($urandom);
    endcase
  endfunction

  dir_row_t dir_tab [] = '{
    '{ROW_CFG, REG_COLUMNS, 16'd1, 16'd0, 0, 16'd0, 0},
    '{ROW_CFG, REG_ROWS_TOTAL, 16'd1, 16'd0, 0, 16'd0, 0},
    '{ROW_FLUSH, 2'd0, 16'd0, 16'd0, 0, 16'd0, 0},
    '{ROW_CELL, 2'd0, 16'h7fff, 16'd5, 0, 16'd0, 0},
    '{ROW_FLUSH, 2'd0, 16'd0, 16'd0, 0, 16'd0, 0},
    '{ROW_FLUSH, 2'd0, 16'd0, 16'd0, 1, 16'h7fff, 1},
    '{ROW_CELL, 2'd0, 16'h8000, 16'd0, 0, 16'd0, 0},
    '{ROW_CELL, 2'd0, 16'd7, 16'hffff, 0, 16'd0, 0},
    '{ROW_FLUSH, 2'd0, 16'd0, 16'd0, 1, 16'h8000, 1},
    '{ROW_CFG, REG_NODATA_ENABLE, 16'd1, 16'd0, 0, 16'd0, 0},
    '{ROW_CFG, REG_NODATA_VALUE, 16'h8000, 16'd0, 0, 16'd0, 0},
    '{ROW_CELL, 2'd0, 16'h8000, 16'd1, 0, 16'd0, 0},
    '{ROW_FLUSH, 2'd0, 16'd0, 16'd0, 0, 16'd0, 0},
    '{ROW_FLUSH, 2'd0, 16'd0, 16'd0, 1, 16'h8000, 1},
    '{ROW_CELL, 2'd0, 16'd0, 16'h8000, 0, 16'd0, 0},
    '{ROW_FLUSH, 2'd0, 16'd0, 16'd0, 0, 16'd0, 0},
    '{ROW_FLUSH, 2'd0, 16'd0, 16'd0, 1, 16'd0, 1},
    '{ROW_CFG, REG_COLUMNS, 16'd3, 16'd0, 0, 16'd0, 0},
    '{ROW_CFG, REG_ROWS_TOTAL, 16'd3, 16'd0, 0, 16'd0, 0},
    '{ROW_CFG, REG_NODATA_VALUE, 16'd5, 16'd0, 0, 16'd0, 0},
    '{ROW_CELL, 2'd0, 16'd1, 16'd3, 0, 16'd0, 0},
    '{ROW_CELL, 2'd0, 16'd2, 16'd0, 0, 16'd0, 0},
    '{ROW_CELL, 2'd0, 16'd2, 16'd9, 0, 16'd0, 0},
    '{ROW_CELL, 2'd0, 16'd5, 16'd1, 0, 16'd0, 0},
    '{ROW_CELL, 2'd0, 16'd1, 16'd5, 0, 16'd0, 0},
    '{ROW_CELL, 2'd0, 16'd2, 16'd4, 0, 16'd0, 0},
    '{ROW_CELL, 2'd0, 16'd2, 16'd2, 0, 16'd0, 0},
    '{ROW_CELL, 2'd0, 16'hfffd, 16'd6, 0, 16'd0, 0},
    '{ROW_CELL, 2'd0, 16'd2, 16'h7fff, 0, 16'd0, 0}
  };

  initial begin
    filt_result_t res;
    bit emitted;
    int unsigned cols, rows, nframes, ph, keep_rows;
    logic [15:0] nd_pick;
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = 0;
    in_tdata = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    cycles = 0;
    items = 0;
    tx_fast = 0;
    rx_fast = 0;
    hold_req = 0;
    columns_reg = 11'd1024;
    rows_reg = 16'd1024;
    nd_en = 0;
    nd_val = '0;
    for (int i = 0; i < MAXC; i++) begin
      upper_buf[i] = '0;
      middle_buf[i] = '0;
      rule_flag_buf[i] = '0;
    end
    clear_window();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_beat(dir_tab[i].kind == ROW_FLUSH ? OP_FLUSH : OP_CELL,
                  dir_tab[i].data, dir_tab[i].rule, emitted, res);
        if (dir_tab[i].has_exp && (!emitted || res.value !== dir_tab[i].exp_value ||
                                   res.last !== dir_tab[i].exp_last)) begin
          mismatches++;
          if (mismatches <= 10) $display("directed row %0d: no result %0d", i,
                                         $signed(dir_tab[i].exp_value));
        end
      end
    end
    repeat (4) send_beat(OP_FLUSH, 16'd0, 16'd0, emitted, res);

    ph = 0;
    while (items < 800 || ph < 8) begin
      cols = $urandom_range(1, 8);
      rows = $urandom_range(1, 6);
      nframes = $urandom_range(1, 3);
      keep_rows = 0;
      case (ph)
        0: cols = 0;
        1: rows = 0;
        2: begin cols = 2047; rows = 1; nframes = 1; keep_rows = 1; end
        4: begin cols = 4; rows = 65535; keep_rows = 3; end
        5: begin cols = 6; rows = 5; hold_req = 1; end
        default: ;
      endcase
      case ($urandom_range(0, 6))
        0: nd_pick = 16'h8000;
        1: nd_pick = 16'h7fff;
        2: nd_pick = 16'($urandom);
        default: nd_pick = 16'($urandom_range(0, 3)) - 16'd1;
      endcase
      write_reg(REG_NODATA_ENABLE, 16'($urandom_range(0, 1)));
      write_reg(REG_NODATA_VALUE, nd_pick);
      write_reg(REG_COLUMNS, 16'(cols));
      write_reg(REG_ROWS_TOTAL, 16'(rows));
      tx_fast = (ph == 5) || ($urandom_range(0, 3) == 0);
      rx_fast = (ph != 5) && ($urandom_range(0, 3) == 0);
      cols = eff_columns();
      if (rows == 0) rows = 1;
      if (keep_rows != 0) begin
        repeat (cols * keep_rows) begin
          send_beat(OP_CELL, pick_cell(), pick_rule(), emitted, res);
          items++;
        end
        repeat (4) begin
          send_beat(OP_FLUSH, 16'd0, 16'd0, emitted, res);
          items++;
        end
      end else begin
        repeat (nframes) begin
          repeat (cols * rows) begin
            if ($urandom_range(0, 19) == 0)
              send_beat(OP_FLUSH, 16'($urandom), 16'($urandom), emitted, res);
            send_beat(OP_CELL, pick_cell(), pick_rule(), emitted, res);
            items++;
          end
          repeat (cols + 1) begin
            send_beat($urandom_range(0, 7) == 0 ? OP_CELL : OP_FLUSH,
                      16'($urandom), 16'($urandom), emitted, res);
            items++;
          end
        end
      end
      ph++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("masked_majority_window_filter_core regression: pass");
    end else begin
      $display("masked_majority_window_filter_core regression: fail");
    end
    $finish;
  end
endmodule

[files.f]
design/mmwf_pkg.sv
design/mmwf_line_buf.sv
design/mmwf_count.sv
design/mmwf_select.sv
design/masked_majority_window_filter_core.sv
verif/testbench.sv
